FILE: src/circular_deque_macros.svh
// Assertion macros used by the circular deque port checker.
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// Implication checked in the cycle it applies.
`define CDQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circular_deque check failed");

// Implication checked in the cycle after the antecedent.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circular_deque check failed");

`endif

FILE: src/cdq_pkg.sv
// Package with constants and types of the circular deque.
`default_nettype none

package cdq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int OP_W          = 2;
    localparam int ST_W          = 2;
    localparam int CAP_W         = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 2'd3;

    localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

    localparam logic [DATA_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] rear;
    } link_t;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic            is_empty;
        logic            is_full;
    } flags_t;

endpackage

`default_nettype wire

FILE: src/cdq_cell.sv
// One slot of the deque store with its stage of the read chain.
`default_nettype none

module cdq_cell #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
    parameter int INDEX = 0
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]         wr_idx,
    input  wire logic signed [cdq_pkg::DATA_W-1:0] wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]         head_idx,
    input  wire logic [$clog2(DEPTH)-1:0]         tail_idx,
    input  wire cdq_pkg::link_t                   link_in,
    output cdq_pkg::link_t                        link_out
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [cdq_pkg::DATA_W-1:0] slot_reg;
    logic                               valid_reg;
    logic signed [cdq_pkg::DATA_W-1:0] front_reg;
    logic signed [cdq_pkg::DATA_W-1:0] rear_reg;
    cdq_pkg::link_t                     link_next;

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == MY_IDX))
        begin
            slot_reg <= wr_data;
        end
    end

    always_comb
    begin
        link_next       = link_in;
        if (head_idx == MY_IDX)
        begin
            link_next.front = slot_reg;
        end
        if (tail_idx == MY_IDX)
        begin
            link_next.rear = slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= link_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= link_next.front;
        rear_reg  <= link_next.rear;
    end

    assign link_out.valid = valid_reg;
    assign link_out.front = front_reg;
    assign link_out.rear  = rear_reg;

endmodule

`default_nettype wire

FILE: src/cdq_ctrl.sv
// Index, count and capacity control of the circular deque.
`default_nettype none

module cdq_ctrl #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [cdq_pkg::OP_W-1:0]     opcode,
    input  wire logic                         cfg_valid,
    input  wire logic [cdq_pkg::CAP_W-1:0]    cfg_data,
    output logic                              wr_en,
    output logic [$clog2(DEPTH)-1:0]          wr_idx,
    output logic [$clog2(DEPTH)-1:0]          head_idx,
    output logic [$clog2(DEPTH)-1:0]          tail_idx,
    output cdq_pkg::flags_t                   flags
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CW    = (IDX_W + 1 > cdq_pkg::CAP_W) ? IDX_W + 1 : cdq_pkg::CAP_W;

    logic [cdq_pkg::CAP_W-1:0] capacity_reg;
    logic [IDX_W-1:0]          head_reg;
    logic [IDX_W-1:0]          head_next;
    logic [IDX_W-1:0]          tail_reg;
    logic [IDX_W-1:0]          tail_next;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [cdq_pkg::ST_W-1:0]  status_reg;
    logic [cdq_pkg::ST_W-1:0]  status_next;
    logic [CW-1:0]             cap_wide;
    logic [CW-1:0]             eff_cap;
    logic                      full_now;

    function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx,
                                                 input logic [CW-1:0] cap);
        logic [CW-1:0] idx_w;
        idx_w = CW'(idx);
        return (idx_w >= cap - CW'(1)) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx,
                                                   input logic [CW-1:0] cap);
        logic [CW-1:0] last;
        last = cap - CW'(1);
        return (idx == '0) ? last[IDX_W-1:0] : idx - IDX_W'(1);
    endfunction

    assign cap_wide = CW'(capacity_reg);

    always_comb
    begin
        if (cap_wide == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (cap_wide > CW'(DEPTH))
        begin
            eff_cap = CW'(DEPTH);
        end
        else
        begin
            eff_cap = cap_wide;
        end
    end

    assign full_now = (count_reg >= eff_cap);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = cdq_pkg::ST_DONE;
        wr_en       = 1'b0;
        wr_idx      = '0;
        case (opcode)
            cdq_pkg::OP_PUSH_FRONT,
            cdq_pkg::OP_PUSH_REAR:
            begin
                if (full_now)
                begin
                    status_next = cdq_pkg::ST_OVERFLOW;
                end
                else if (count_reg == '0)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = CW'(1);
                    wr_en      = accept;
                end
                else if (opcode == cdq_pkg::OP_PUSH_FRONT)
                begin
                    head_next  = step_down(head_reg, eff_cap);
                    wr_idx     = head_next;
                    count_next = count_reg + CW'(1);
                    wr_en      = accept;
                end
                else
                begin
                    tail_next  = step_up(tail_reg, eff_cap);
                    wr_idx     = tail_next;
                    count_next = count_reg + CW'(1);
                    wr_en      = accept;
                end
            end
            cdq_pkg::OP_POP_FRONT,
            cdq_pkg::OP_POP_REAR:
            begin
                if (count_reg == '0)
                begin
                    status_next = cdq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    if (count_next == '0)
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else if (opcode == cdq_pkg::OP_POP_FRONT)
                    begin
                        head_next = step_up(head_reg, eff_cap);
                    end
                    else
                    begin
                        tail_next = step_down(tail_reg, eff_cap);
                    end
                end
            end
            default:
            begin
                status_next = cdq_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= cdq_pkg::CAP_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            status_reg   <= cdq_pkg::ST_DONE;
        end
        else
        begin
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end
            if (accept)
            begin
                head_reg   <= head_next;
                tail_reg   <= tail_next;
                count_reg  <= count_next;
                status_reg <= status_next;
            end
        end
    end

    assign head_idx       = head_reg;
    assign tail_idx       = tail_reg;
    assign flags.status   = status_reg;
    assign flags.is_empty = (count_reg == '0);
    assign flags.is_full  = full_now;

endmodule

`default_nettype wire

FILE: src/circular_deque.sv
// Circular deque: control, a row of slot cells with a read chain, done and output registers.
// A result passes from launch_reg along the cells' read chain into the done register, then to m_axis.
// One transaction is in flight at a time; the front/rear read walks the cell row,
//   one cell a cycle, and the next item waits until its result moves to the output register.
// s_axis_tready rises once a result enters the output register, even while it waits on m_axis.
// Reset: asynchronous, active low; empty deque, capacity 16, slots undefined until written.
`default_nettype none

module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [cdq_pkg::CAP_W-1:0]    cfg_data,      // capacity
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [cdq_pkg::DATA_W-1:0]   s_axis_tdata,  // value
    input  wire logic [cdq_pkg::OP_W-1:0]     s_axis_tuser,  // opcode
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [2*cdq_pkg::DATA_W-1:0]      m_axis_tdata,  // front_value, rear_value
    output logic [cdq_pkg::ST_W+1:0]          m_axis_tuser   // status, is_empty, is_full
);

    localparam int IDX_W = $clog2(DEPTH);

    logic                               accept;
    logic                               busy_reg;
    logic                               launch_reg;
    logic                               wr_en;
    logic [IDX_W-1:0]                   wr_idx;
    logic [IDX_W-1:0]                   head_idx;
    logic [IDX_W-1:0]                   tail_idx;
    cdq_pkg::flags_t                    flags;
    cdq_pkg::link_t                     chain [DEPTH+1];
    logic                               done_valid_reg;
    logic signed [cdq_pkg::DATA_W-1:0]  done_front_reg;
    logic signed [cdq_pkg::DATA_W-1:0]  done_rear_reg;
    cdq_pkg::flags_t                    done_flags_reg;
    logic                               m_valid_reg;
    logic signed [cdq_pkg::DATA_W-1:0]  m_front_reg;
    logic signed [cdq_pkg::DATA_W-1:0]  m_rear_reg;
    cdq_pkg::flags_t                    m_flags_reg;
    logic                               m_free;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !busy_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .opcode    (s_axis_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .head_idx  (head_idx),
        .tail_idx  (tail_idx),
        .flags     (flags)
    );

    assign chain[0].valid = launch_reg;
    assign chain[0].front = cdq_pkg::EMPTY_VALUE;
    assign chain[0].rear  = cdq_pkg::EMPTY_VALUE;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cdq_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (wr_en),
            .wr_idx   (wr_idx),
            .wr_data  (s_axis_tdata),
            .head_idx (head_idx),
            .tail_idx (tail_idx),
            .link_in  (chain[i]),
            .link_out (chain[i+1])
        );
    end

    assign m_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            launch_reg     <= 1'b0;
            done_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            launch_reg <= accept;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            if (chain[DEPTH].valid)
            begin
                done_valid_reg <= 1'b1;
            end
            if (done_valid_reg && m_free)
            begin
                done_valid_reg <= 1'b0;
                busy_reg       <= 1'b0;
                m_valid_reg    <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain[DEPTH].valid)
        begin
            done_flags_reg <= flags;
            done_front_reg <= flags.is_empty ? cdq_pkg::EMPTY_VALUE : chain[DEPTH].front;
            done_rear_reg  <= flags.is_empty ? cdq_pkg::EMPTY_VALUE : chain[DEPTH].rear;
        end
        if (done_valid_reg && m_free)
        begin
            m_flags_reg <= done_flags_reg;
            m_front_reg <= done_front_reg;
            m_rear_reg  <= done_rear_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_rear_reg, m_front_reg};
    assign m_axis_tuser  = {m_flags_reg.is_full, m_flags_reg.is_empty, m_flags_reg.status};

endmodule

`default_nettype wire

FILE: src/cdq_checker.sv
// Port checker of the circular deque and its bind to the top level.
`default_nettype none

`include "circular_deque_macros.svh"

module cdq_port_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    input  wire logic                         s_axis_tready,
    input  wire logic                         m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    input  wire logic [2*cdq_pkg::DATA_W-1:0] m_axis_tdata,
    input  wire logic [cdq_pkg::ST_W+1:0]     m_axis_tuser
);

    logic [cdq_pkg::ST_W-1:0]                   status;
    logic                                       is_empty;
    logic                                       is_full;
    logic                                       underflow;
    logic                                       out_wait;
    logic                                       empty_word;
    logic [2*cdq_pkg::DATA_W+cdq_pkg::ST_W+1:0] out_word;

    assign status     = m_axis_tuser[cdq_pkg::ST_W-1:0];
    assign is_empty   = m_axis_tuser[cdq_pkg::ST_W];
    assign is_full    = m_axis_tuser[cdq_pkg::ST_W+1];
    assign underflow  = (status == cdq_pkg::ST_UNDERFLOW);
    assign out_wait   = m_axis_tvalid && !m_axis_tready;
    assign out_word   = {m_axis_tuser, m_axis_tdata};
    assign empty_word = (m_axis_tdata == {2{cdq_pkg::EMPTY_VALUE}});

    `CDQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, m_axis_tvalid && $stable(out_word))
    `CDQ_ASSERT_IMPLY(a_empty_value, clk, rst_n, m_axis_tvalid && is_empty, empty_word)
    `CDQ_ASSERT_IMPLY(a_empty_not_full, clk, rst_n, m_axis_tvalid, !(is_empty && is_full))
    `CDQ_ASSERT_IMPLY(a_underflow_empty, clk, rst_n, m_axis_tvalid && underflow, is_empty)
    `CDQ_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind circular_deque cdq_port_checker u_cdq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
